// ===== design/psplat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package psplat_pkg;
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int DIV_BITS   = 48;

   localparam logic [2:0] CSR_ROW_ZERO  = 3'd0;
   localparam logic [2:0] CSR_ROW_ONE   = 3'd1;
   localparam logic [2:0] CSR_ROW_TWO   = 3'd2;
   localparam logic [2:0] CSR_ROW_THREE = 3'd3;
   localparam logic [2:0] CSR_WIDTH     = 3'd4;
   localparam logic [2:0] CSR_HEIGHT    = 3'd5;
   localparam logic [2:0] CSR_COLOR     = 3'd6;

   typedef struct packed {
      logic               vld;
      logic signed [31:0] hx;
      logic signed [31:0] hy;
      logic signed [31:0] hz;
      logic signed [31:0] hw;
   } homog_type;
endpackage
`default_nettype wire

// ===== design/point_projection_splat.sv =====
`timescale 1ns / 1ps
`default_nettype none
// stages from input transaction to pixel write: 3 matrix, 48 divide, 3 screen
// throughput: one point per cycle unless the output stalls; the 48-stage divider sets the latency
// a stalled output freezes the whole pipeline, nothing is lost
// points that miss the depth range or the image produce no transaction
// synchronous active-high reset clears valid bits and loads the identity matrix, 640x480
module point_projection_splat (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // point_x, point_y, point_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // pixel_x, pixel_y, pixel_index, pixel_color
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   localparam int N = psplat_pkg::DIV_BITS;

   logic [63:0] rows_ff [4];
   logic [12:0] width_ff, height_ff;
   logic [47:0] color_ff;
   logic [12:0] wd, ht;
   logic        en;

   psplat_pkg::homog_type hom;
   logic signed [48:0] nx, ny, nz;
   logic [N-1:0] dv_ff;
   logic         va_ff, vb_ff;
   logic [11:0]  sx, sy;
   logic         okx, oky;
   logic         rsp_valid_ff;
   logic [11:0]  ox_ff, oy_ff;
   logic [23:0]  oi_ff;

   assign wd = (width_ff > 13'(psplat_pkg::MAX_WIDTH)) ? 13'(psplat_pkg::MAX_WIDTH) : width_ff;
   assign ht = (height_ff > 13'(psplat_pkg::MAX_HEIGHT)) ? 13'(psplat_pkg::MAX_HEIGHT)
                                                         : height_ff;
   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff[0] <= 64'd4096;
         rows_ff[1] <= 64'd268435456;
         rows_ff[2] <= 64'd17592186044416;
         rows_ff[3] <= 64'd1152921504606846976;
         width_ff   <= 13'd640;
         height_ff  <= 13'd480;
         color_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            psplat_pkg::CSR_ROW_ZERO:  rows_ff[0] <= csr_wdata;
            psplat_pkg::CSR_ROW_ONE:   rows_ff[1] <= csr_wdata;
            psplat_pkg::CSR_ROW_TWO:   rows_ff[2] <= csr_wdata;
            psplat_pkg::CSR_ROW_THREE: rows_ff[3] <= csr_wdata;
            psplat_pkg::CSR_WIDTH:     width_ff   <= csr_wdata[12:0];
            psplat_pkg::CSR_HEIGHT:    height_ff  <= csr_wdata[12:0];
            psplat_pkg::CSR_COLOR:     color_ff   <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   psplat_xform u_xform (
      .clock(clock), .reset(reset), .enable(en), .in_vld(req_tvalid),
      .px(req_tdata[31:0]), .py(req_tdata[63:32]), .pz(req_tdata[95:64]),
      .rows(rows_ff), .res(hom)
   );

   psplat_div u_div_x (.clock(clock), .enable(en), .num(hom.hx), .den(hom.hw), .quo(nx));
   psplat_div u_div_y (.clock(clock), .enable(en), .num(hom.hy), .den(hom.hw), .quo(ny));
   psplat_div u_div_z (.clock(clock), .enable(en), .num(hom.hz), .den(hom.hw), .quo(nz));

   psplat_axis u_axis_x (.clock(clock), .enable(en), .n(nx), .size(wd), .pix(sx), .ok(okx));
   psplat_axis u_axis_y (.clock(clock), .enable(en), .n(ny), .size(ht), .pix(sy), .ok(oky));

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff        <= '0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         dv_ff        <= {dv_ff[N-2:0], hom.vld && (hom.hw != 32'sd0)};
         va_ff        <= dv_ff[N-1] && (nz >= -49'sd65536) && (nz <= 49'sd65536);
         vb_ff        <= va_ff;
         rsp_valid_ff <= vb_ff && okx && oky;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ox_ff <= sx;
         oy_ff <= sy;
         oi_ff <= 24'(25'(sy) * 25'(wd) + 25'(sx));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {color_ff, oi_ff, oy_ff, ox_ff};

   a_x_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (13'(rsp_tdata[11:0]) < wd))
      else $error("pixel column outside image");
   a_y_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (13'(rsp_tdata[23:12]) < ht))
      else $error("pixel row outside image");
endmodule
`default_nettype wire

// ===== design/psplat_xform.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psplat_xform (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        enable,
   input  wire logic        in_vld,
   input  wire logic [31:0] px,
   input  wire logic [31:0] py,
   input  wire logic [31:0] pz,
   input  wire logic [63:0] rows [4],
   output psplat_pkg::homog_type res
);
   logic signed [47:0] prod_ff [4][4];
   logic signed [49:0] acc_ff [4];
   logic signed [31:0] h_ff [4];
   logic [2:0]         vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
   end

   for (genvar r = 0; r < 4; r++) begin : g_row
      logic signed [15:0] m0, m1, m2, m3;
      logic signed [49:0] sum_in;
      logic signed [49:0] adj;
      logic signed [37:0] q;
      logic signed [31:0] sat_in;
      assign m0 = rows[r][15:0];
      assign m1 = rows[r][31:16];
      assign m2 = rows[r][47:32];
      assign m3 = rows[r][63:48];
      assign sum_in = 50'(prod_ff[r][0]) + 50'(prod_ff[r][1]) + 50'(prod_ff[r][2])
                    + 50'(prod_ff[r][3]);
      // truncate toward zero on the divide by 4096
      assign adj = acc_ff[r] + (acc_ff[r][49] ? 50'sd4095 : 50'sd0);
      assign q   = 38'(adj >>> 12);
      always_comb begin
         if (q > 38'sd2147483647)       sat_in = 32'sh7fffffff;
         else if (q < -38'sd2147483648) sat_in = 32'sh80000000;
         else                           sat_in = q[31:0];
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            prod_ff[r][0] <= m0 * $signed(px);
            prod_ff[r][1] <= m1 * $signed(py);
            prod_ff[r][2] <= m2 * $signed(pz);
            prod_ff[r][3] <= {{16{m3[15]}}, m3, 16'd0};
            acc_ff[r]     <= sum_in;
            h_ff[r]       <= sat_in;
         end
      end
   end

   assign res.vld = vld_ff[2];
   assign res.hx  = h_ff[0];
   assign res.hy  = h_ff[1];
   assign res.hz  = h_ff[2];
   assign res.hw  = h_ff[3];
endmodule
`default_nettype wire

// ===== design/psplat_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psplat_div (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic signed [48:0]      quo
);
   localparam int N = psplat_pkg::DIV_BITS;
   logic [31:0]  rem_ff [N];
   logic [N-1:0] nbits_ff [N];
   logic [N-1:0] q_ff [N];
   logic [31:0]  d_ff [N];
   logic         neg_ff [N];

   logic [31:0] num_mag, den_mag;
   assign num_mag = num[31] ? 32'(-33'(num)) : 32'(num);
   assign den_mag = den[31] ? 32'(-33'(den)) : 32'(den);

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [31:0]  rem_p, d_p;
      logic [N-1:0] nb_p, q_p;
      logic         neg_p;
      logic [32:0]  trial;
      logic         take;
      if (k == 0) begin : g_first
         assign rem_p = '0;
         assign nb_p  = {num_mag, 16'd0};
         assign q_p   = '0;
         assign d_p   = den_mag;
         assign neg_p = num[31] ^ den[31];
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign nb_p  = nbits_ff[k-1];
         assign q_p   = q_ff[k-1];
         assign d_p   = d_ff[k-1];
         assign neg_p = neg_ff[k-1];
      end
      assign trial = {rem_p, nb_p[N-1]};
      assign take  = trial >= {1'b0, d_p};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]   <= take ? 32'(trial - {1'b0, d_p}) : trial[31:0];
            nbits_ff[k] <= {nb_p[N-2:0], 1'b0};
            q_ff[k]     <= {q_p[N-2:0], take};
            d_ff[k]     <= d_p;
            neg_ff[k]   <= neg_p;
         end
      end
   end

   assign quo = neg_ff[N-1] ? -$signed({1'b0, q_ff[N-1]}) : $signed({1'b0, q_ff[N-1]});
endmodule
`default_nettype wire

// ===== design/psplat_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psplat_axis (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic signed [48:0] n,
   input  wire logic [12:0]        size,
   output logic [11:0]             pix,
   output logic                    ok
);
   logic signed [63:0] t0_ff;
   logic signed [63:0] t;
   logic signed [63:0] q;
   logic signed [63:0] n_ext;
   logic signed [63:0] size_ext;
   logic [11:0]        pix_ff;
   logic               ok_ff;

   // operands widened first so that the product keeps every bit
   assign n_ext    = 64'(n) + 64'sd65536;
   assign size_ext = $signed({51'd0, size});
   assign t = t0_ff + 64'sd65536;
   assign q = t >>> 17;

   always_ff @(posedge clock) begin
      if (enable) begin
         t0_ff  <= n_ext * size_ext;
         // truncation toward zero: a small negative value lands on 0
         ok_ff  <= !(t <= -64'sd131072) && (t[63] || q < $signed({51'd0, size}));
         pix_ff <= t[63] ? 12'd0 : q[11:0];
      end
   end

   assign pix = pix_ff;
   assign ok  = ok_ff;
endmodule
`default_nettype wire
